@@ rtl/rrltp_pkg.sv @@
// types and constants of the round-robin / lottery task picker
// used by round_robin_lottery_task_picker_unit; depends on nothing

package rrltp_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHARGE,
        ST_DEDUCT,
        ST_SELECT,
        ST_RR_MOD,
        ST_RR_WALK,
        ST_DIV,
        ST_LOT_WALK,
        ST_DONE
    } state_t;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic ALG_ROUND_ROBIN = 1'b0;
    localparam logic ALG_LOTTERY     = 1'b1;

    localparam logic [1:0] CFG_ALGORITHM   = 2'd0;
    localparam logic [1:0] CFG_TASK_COUNT  = 2'd1;
    localparam logic [1:0] CFG_TICKET_UNIT = 2'd2;

    localparam int POOL_W = 26;
    localparam logic [POOL_W-1:0] POOL_MAX = '1;
    localparam int DRAW_W = 31;
    localparam int UNIT_W = 16;
    localparam int TASK_OUT_W = 5;

    localparam logic [5:0]        TASK_COUNT_RESET  = 6'd3;
    localparam logic [UNIT_W-1:0] TICKET_UNIT_RESET = 16'd1000;

endpackage

@@ rtl/round_robin_lottery_task_picker_unit.sv @@
// round-robin / lottery task picker, adders and comparators under a sequencer
// depends on rrltp_pkg
// steps: a start sums the tickets of the n tasks (n is the clamped task count); a tick while
//   halted reports no task left, else a done task is charged, then round-robin takes the next
//   index mod n and walks to an unfinished task, lottery takes the draw mod pool bit-serially
// throughput: one word at a time, next word taken once the result sits in the output register
// reset: config to algorithm 0, task count 3, ticket unit 1000; task maps, pool, halt cleared

module round_robin_lottery_task_picker_unit
    import rrltp_pkg::*;
#(
    parameter int TASK_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // current_done[0], random_draw[31:1]
    input  logic        s_tuser,   // command[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // next_task[4:0], no_task_left[5], first_run[6],
                                   // tickets_left[32:7], zero[39:33]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_W = $clog2(TASK_SLOTS);
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int TK_W  = UNIT_W + CNT_W;
    localparam int ACC_W = UNIT_W + $clog2(TASK_SLOTS * (TASK_SLOTS + 1) / 2 + 1);
    localparam int SAT_W = (ACC_W > POOL_W) ? ACC_W : POOL_W;
    localparam int DED_W = (TK_W > POOL_W) ? TK_W : POOL_W;
    localparam int TW_W  = (IDX_W > TASK_OUT_W) ? IDX_W : TASK_OUT_W;

    state_t state_reg, state_next;

    logic                  algo_reg;
    logic [5:0]            tc_reg;
    logic [UNIT_W-1:0]     unit_reg;

    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [TASK_SLOTS-1:0] fin_reg, fin_next;
    logic [TASK_SLOTS-1:0] sta_reg, sta_next;
    logic [POOL_W-1:0]     pool_reg, pool_next;
    logic                  halted_reg, halted_next;

    logic [DRAW_W-1:0]     dvd_reg, dvd_next;
    logic [POOL_W-1:0]     rem_reg, rem_next;
    logic [4:0]            bit_reg, bit_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [TK_W-1:0]       tk_reg, tk_next;

    logic [IDX_W-1:0]      res_task_reg, res_task_next;
    logic                  res_none_reg, res_none_next;
    logic                  res_first_reg, res_first_next;

    logic                  m_valid_reg, m_valid_next;
    logic [TASK_OUT_W-1:0] m_task_reg, m_task_next;
    logic                  m_none_reg, m_none_next;
    logic                  m_first_reg, m_first_next;
    logic [POOL_W-1:0]     m_pool_reg, m_pool_next;

    logic [6:0]            n_full;
    logic [CNT_W-1:0]      n;
    logic [CNT_W-1:0]      cur_inc;
    logic [SAT_W-1:0]      acc_sat;
    logic [DED_W-1:0]      pool_ded;
    logic [DED_W-1:0]      tk_ded;
    logic [POOL_W:0]       trial;
    logic [ACC_W-1:0]      acc_sum;
    logic [SAT_W-1:0]      acc_sum_ext;
    logic [IDX_W-1:0]      idx_sel;
    logic [IDX_W-1:0]      step_sel;
    logic                  pick_en;
    logic [IDX_W-1:0]      pick_id;
    logic                  halt_en;
    logic [TW_W-1:0]       res_task_wide;

    // clamped task count
    always_comb
    begin
        if (tc_reg == 6'd0)
            n_full = 7'd1;
        else if ({1'b0, tc_reg} > 7'(TASK_SLOTS))
            n_full = 7'(TASK_SLOTS);
        else
            n_full = {1'b0, tc_reg};
    end

    assign n           = CNT_W'(n_full);
    assign cur_inc     = CNT_W'(cur_reg) + CNT_W'(1);
    assign acc_sat     = SAT_W'(acc_reg);
    assign pool_ded    = DED_W'(pool_reg);
    assign tk_ded      = DED_W'(tk_reg);
    assign trial       = {rem_reg, dvd_reg[DRAW_W-1]};
    assign acc_sum     = acc_reg + ACC_W'(tk_reg);
    assign acc_sum_ext = SAT_W'(acc_sum);
    assign idx_sel     = idx_reg[IDX_W-1:0];
    assign step_sel    = step_reg[IDX_W-1:0];
    assign res_task_wide = TW_W'(res_task_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {7'd0, m_pool_reg, m_first_reg, m_none_reg, m_task_reg};

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        fin_next       = fin_reg;
        sta_next       = sta_reg;
        pool_next      = pool_reg;
        halted_next    = halted_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        tk_next        = tk_reg;
        res_task_next  = res_task_reg;
        res_none_next  = res_none_reg;
        res_first_next = res_first_reg;
        m_valid_next   = m_valid_reg;
        m_task_next    = m_task_reg;
        m_none_next    = m_none_reg;
        m_first_next   = m_first_reg;
        m_pool_next    = m_pool_reg;
        pick_en        = 1'b0;
        pick_id        = '0;
        halt_en        = 1'b0;

        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    dvd_next  = s_tdata[31:1];
                    if (s_tuser == CMD_START)
                    begin
                        fin_next   = '0;
                        sta_next   = '0;
                        acc_next   = '0;
                        tk_next    = TK_W'(unit_reg);
                        step_next  = '0;
                        state_next = ST_SUM;
                    end
                    else if (halted_reg)
                    begin
                        res_task_next  = '0;
                        res_none_next  = 1'b1;
                        res_first_next = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else if (s_tdata[0] && !fin_reg[cur_reg])
                        state_next = ST_CHARGE;
                    else
                        state_next = ST_SELECT;
                end
            end
            ST_SUM:
            begin
                if (step_reg == n)
                begin
                    if (acc_sat > SAT_W'(POOL_MAX))
                        pool_next = POOL_MAX;
                    else
                        pool_next = acc_sat[POOL_W-1:0];
                    cur_next       = '0;
                    sta_next[0]    = 1'b1;
                    halted_next    = 1'b0;
                    res_task_next  = '0;
                    res_none_next  = 1'b0;
                    res_first_next = 1'b1;
                    state_next     = ST_DONE;
                end
                else
                begin
                    acc_next  = acc_sum;
                    tk_next   = tk_reg + TK_W'(unit_reg);
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_CHARGE:
            begin
                tk_next    = TK_W'(cur_inc) * TK_W'(unit_reg);
                state_next = ST_DEDUCT;
            end
            ST_DEDUCT:
            begin
                fin_next[cur_reg] = 1'b1;
                if (pool_ded > tk_ded)
                    pool_next = POOL_W'(pool_ded - tk_ded);
                else
                    pool_next = '0;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                if (algo_reg == ALG_ROUND_ROBIN)
                begin
                    idx_next   = cur_inc;
                    state_next = ST_RR_MOD;
                end
                else if (pool_reg == '0)
                    halt_en = 1'b1;
                else
                begin
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_RR_MOD:
            begin
                if (idx_reg >= n)
                    idx_next = idx_reg - n;
                else
                begin
                    step_next  = '0;
                    state_next = ST_RR_WALK;
                end
            end
            ST_RR_WALK:
            begin
                if (!fin_reg[idx_sel])
                begin
                    pick_en = 1'b1;
                    pick_id = idx_sel;
                end
                else if (step_reg == n - CNT_W'(1))
                    halt_en = 1'b1;
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == n)
                        idx_next = '0;
                    else
                        idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, pool_reg})
                    rem_next = POOL_W'(trial - {1'b0, pool_reg});
                else
                    rem_next = trial[POOL_W-1:0];
                dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
                if (bit_reg == 5'(DRAW_W - 1))
                begin
                    acc_next   = '0;
                    tk_next    = TK_W'(unit_reg);
                    step_next  = '0;
                    state_next = ST_LOT_WALK;
                end
                else
                    bit_next = bit_reg + 5'd1;
            end
            ST_LOT_WALK:
            begin
                if (step_reg == n)
                    halt_en = 1'b1;
                else
                begin
                    if (!fin_reg[step_sel] && (acc_sum_ext > SAT_W'(rem_reg)))
                    begin
                        pick_en = 1'b1;
                        pick_id = step_sel;
                    end
                    else
                    begin
                        if (!fin_reg[step_sel])
                            acc_next = acc_sum;
                        tk_next   = tk_reg + TK_W'(unit_reg);
                        step_next = step_reg + CNT_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_task_next  = res_task_wide[TASK_OUT_W-1:0];
                    m_none_next  = res_none_reg;
                    m_first_next = res_first_reg;
                    m_pool_next  = pool_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (pick_en)
        begin
            res_task_next     = pick_id;
            res_none_next     = 1'b0;
            res_first_next    = !sta_reg[pick_id];
            sta_next[pick_id] = 1'b1;
            cur_next          = pick_id;
            state_next        = ST_DONE;
        end
        else if (halt_en)
        begin
            halted_next    = 1'b1;
            res_task_next  = '0;
            res_none_next  = 1'b1;
            res_first_next = 1'b0;
            state_next     = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algo_reg <= ALG_ROUND_ROBIN;
            tc_reg   <= TASK_COUNT_RESET;
            unit_reg <= TICKET_UNIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALGORITHM:   algo_reg <= cfg_data[0];
                CFG_TASK_COUNT:  tc_reg   <= cfg_data[5:0];
                CFG_TICKET_UNIT: unit_reg <= cfg_data;
                default:         algo_reg <= algo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            fin_reg     <= '0;
            sta_reg     <= '0;
            pool_reg    <= '0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            fin_reg     <= fin_next;
            sta_reg     <= sta_next;
            pool_reg    <= pool_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        idx_reg       <= idx_next;
        step_reg      <= step_next;
        acc_reg       <= acc_next;
        tk_reg        <= tk_next;
        res_task_reg  <= res_task_next;
        res_none_reg  <= res_none_next;
        res_first_reg <= res_first_next;
        m_task_reg    <= m_task_next;
        m_none_reg    <= m_none_next;
        m_first_reg   <= m_first_next;
        m_pool_reg    <= m_pool_next;
    end

    // a word that reports nothing left names task 0 and is never a first run
    a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_none_reg) |-> (m_task_reg == '0 && !m_first_reg))
        else $error("no-task word carries a task");

    // the reduced draw stays below the pool during the ticket walk
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOT_WALK) |-> (rem_reg < pool_reg))
        else $error("lottery remainder not below pool");

    // round-robin walk index stays inside the active tasks
    a_rr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RR_WALK) |-> (idx_reg < n))
        else $error("round-robin index out of range");

    // a start word leaves the block unhalted with task 0 marked started
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM && step_reg == n) |=> (!halted_reg && sta_reg[0]
            && cur_reg == '0))
        else $error("start did not restart the task set");

endmodule

@@ tb/sv/rrltp_schedule_checker.sv @@
// checker for round_robin_lottery_task_picker_unit: watches the config, input and result
// channels, predicts each pick from its own copy of the scheduler state and compares
// depends on rrltp_pkg

module rrltp_schedule_checker
    import rrltp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          outstanding,
    output int          errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 32;

    typedef struct packed {
        logic [POOL_W-1:0]     pool;
        logic                  first;
        logic                  no_left;
        logic [TASK_OUT_W-1:0] task_id;
    } pick_t;

    pick_t pending_picks[$];
    int    err_count = 0;

    logic              alg_sel    = ALG_ROUND_ROBIN;
    logic [5:0]        task_cnt   = TASK_COUNT_RESET;
    logic [UNIT_W-1:0] unit_sz    = TICKET_UNIT_RESET;
    logic [4:0]        cur_task   = '0;
    logic [SLOTS-1:0]  done_map   = '0;
    logic [SLOTS-1:0]  seen_map   = '0;
    logic [POOL_W-1:0] pool       = '0;
    logic              stuck      = 1'b0;

    function automatic longint unsigned tickets_for(input int unsigned idx);
        return (longint'(idx) + 1) * longint'(unit_sz);
    endfunction

    function automatic pick_t make_pick(input int unsigned id, input logic none,
                                        input logic first);
        pick_t p;
        p.task_id = id[TASK_OUT_W-1:0];
        p.no_left = none;
        p.first   = first;
        p.pool    = pool;
        return p;
    endfunction

    task automatic schedule_next(input logic cmd, input logic done, input logic [30:0] draw,
                                 output pick_t pick);
        int unsigned       n;
        int unsigned       id;
        int                chosen;
        longint unsigned   sum;
        longint unsigned   share;
        longint unsigned   target;
        longint unsigned   acc;
        n = 32'(task_cnt);
        if (n < 1) n = 1;
        if (n > SLOTS) n = SLOTS;
        chosen = -1;
        if (cmd == CMD_START) begin
            sum = 0;
            for (int unsigned i = 0; i < n; i++) sum += tickets_for(i);
            done_map = '0;
            seen_map = '0;
            seen_map[0] = 1'b1;
            pool = (sum > POOL_MAX) ? POOL_MAX : sum[POOL_W-1:0];
            cur_task = '0;
            stuck = 1'b0;
            pick = make_pick(0, 1'b0, 1'b1);
            return;
        end
        if (stuck) begin
            pick = make_pick(0, 1'b1, 1'b0);
            return;
        end
        if (done && !done_map[cur_task]) begin
            share = tickets_for(cur_task);
            done_map[cur_task] = 1'b1;
            pool = (pool > share) ? POOL_W'(pool - share) : '0;
        end
        if (alg_sel == ALG_ROUND_ROBIN) begin
            for (int unsigned k = 1; k <= n; k++) begin
                id = (int'(cur_task) + k) % n;
                if (!done_map[id]) begin
                    chosen = id;
                    break;
                end
            end
        end else if (pool != 0) begin
            target = longint'(draw) % longint'(pool);
            acc = 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (!done_map[i]) begin
                    acc += tickets_for(i);
                    if (acc > target) begin
                        chosen = i;
                        break;
                    end
                end
            end
        end
        if (chosen < 0) begin
            stuck = 1'b1;
            pick = make_pick(0, 1'b1, 1'b0);
        end else begin
            pick = make_pick(chosen, 1'b0, !seen_map[chosen]);
            seen_map[chosen] = 1'b1;
            cur_task = chosen[4:0];
        end
    endtask

    task automatic flag_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        pick_t want;
        pick_t got;
        if (!rst_n) begin
            alg_sel  = ALG_ROUND_ROBIN;
            task_cnt = TASK_COUNT_RESET;
            unit_sz  = TICKET_UNIT_RESET;
            cur_task = '0;
            done_map = '0;
            seen_map = '0;
            pool     = '0;
            stuck    = 1'b0;
            pending_picks.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[32:0];
                if (pending_picks.size() == 0) begin
                    err_count++;
                    $display("%0t: result word with none expected, actual %h", $time, m_tdata);
                end else begin
                    want = pending_picks.pop_front();
                    flag_field("next_task", want.task_id, got.task_id);
                    flag_field("no_task_left", want.no_left, got.no_left);
                    flag_field("first_run", want.first, got.first);
                    flag_field("tickets_left", want.pool, got.pool);
                end
                flag_field("pad bits", 0, m_tdata[39:33]);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ALGORITHM:   alg_sel  = cfg_data[0];
                    CFG_TASK_COUNT:  task_cnt = cfg_data[5:0];
                    CFG_TICKET_UNIT: unit_sz  = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                schedule_next(s_tuser, s_tdata[0], s_tdata[31:1], want);
                pending_picks.push_back(want);
            end
            outstanding <= pending_picks.size();
        end
        errors <= err_count;
    end

endmodule

@@ tb/sv/tb_round_robin_lottery_task_picker_unit.sv @@
// top of the task picker testbench: clock, reset, stimulus and verdict
// depends on rrltp_pkg, round_robin_lottery_task_picker_unit and rrltp_schedule_checker

module tb_round_robin_lottery_task_picker_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rrltp_pkg::*;

    localparam int RANDOM_WORDS = 850;
    localparam int RX_FULL   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_TOGGLE = 3;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = CMD_START;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ALGORITHM;
    logic [15:0] cfg_data  = '0;

    int outstanding;
    int errors;

    int          burst_left = 0;
    int unsigned rx_mode    = RX_FULL;
    int unsigned rx_left    = 0;
    logic [5:0]  cnt_shadow = TASK_COUNT_RESET;
    int unsigned fin_cnt    = 0;

    round_robin_lottery_task_picker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rrltp_schedule_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .outstanding (outstanding),
        .errors      (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb_round_robin_lottery_task_picker_unit NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(RX_FULL, RX_TOGGLE);
            rx_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FULL:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    function automatic int unsigned live_tasks();
        if (cnt_shadow == 0) return 1;
        if (cnt_shadow > 32) return 32;
        return 32'(cnt_shadow);
    endfunction

    function automatic logic [30:0] random_draw();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) return 31'($urandom);
        if (r < 15) return 31'($urandom_range(0, 100));
        if (r < 17) return '0;
        if (r < 19) return '1;
        return 31'($urandom_range(0, 40000));
    endfunction

    task automatic send_word(input logic cmd, input logic done, input logic [30:0] draw);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {draw, done};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        if (cmd == CMD_START)
            fin_cnt = 0;
        else if (done && fin_cnt < live_tasks())
            fin_cnt++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic program_regs(input bit wr_alg, input bit wr_cnt, input bit wr_unit,
                                input logic [15:0] alg_d, input logic [15:0] cnt_d,
                                input logic [15:0] unit_d);
        wait_idle();
        if (wr_alg) cfg_write(CFG_ALGORITHM, alg_d);
        if (wr_cnt)
        begin
            cfg_write(CFG_TASK_COUNT, cnt_d);
            cnt_shadow = cnt_d[5:0];
        end
        if (wr_unit) cfg_write(CFG_TICKET_UNIT, unit_d);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned random_sent;
        int unsigned phase_len;
        int unsigned done_pct;
        int unsigned r;
        logic [2:0]  sel;
        logic [15:0] alg_d;
        logic [15:0] cnt_d;
        logic [15:0] unit_d;
        logic        cmd;
        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // ticks before any start, done on an empty pool
        send_word(CMD_TICK, 1'b0, '0);
        send_word(CMD_TICK, 1'b1, '1);
        program_regs(1, 0, 0, {15'h7FFF, ALG_LOTTERY}, '0, '0);
        send_word(CMD_TICK, 1'b0, '0);
        send_word(CMD_TICK, 1'b1, '0);
        // lottery run to completion, then a tick while halted
        send_word(CMD_START, 1'b0, '1);
        send_word(CMD_TICK, 1'b0, '0);
        send_word(CMD_TICK, 1'b0, '1);
        send_word(CMD_TICK, 1'b1, 31'd5999);
        send_word(CMD_TICK, 1'b1, 31'd1234);
        send_word(CMD_TICK, 1'b1, '0);
        send_word(CMD_TICK, 1'b0, '0);
        // shrink the task count mid-run so the walk can miss
        send_word(CMD_START, 1'b1, '0);
        program_regs(0, 1, 0, '0, 16'd1, '0);
        send_word(CMD_TICK, 1'b0, '1);
        // zero task count, widest ticket unit, round-robin
        program_regs(1, 1, 1, {15'h0000, ALG_ROUND_ROBIN}, 16'hFFC0, 16'hFFFF);
        send_word(CMD_START, 1'b0, '0);
        send_word(CMD_TICK, 1'b0, '1);
        send_word(CMD_TICK, 1'b1, '0);
        // task count above the slots, smallest unit, lottery
        program_regs(1, 1, 1, {15'h5555, ALG_LOTTERY}, 16'd63, 16'd1);
        send_word(CMD_START, 1'b0, '0);
        send_word(CMD_TICK, 1'b0, '1);
        send_word(CMD_TICK, 1'b1, 31'd527);
        send_word(CMD_TICK, 1'b1, '0);
        // all slots, widest unit, round-robin
        program_regs(1, 1, 1, {15'h2AAA, ALG_ROUND_ROBIN}, 16'd32, 16'hFFFF);
        send_word(CMD_START, 1'b0, '0);
        send_word(CMD_TICK, 1'b0, '0);
        send_word(CMD_TICK, 1'b1, '1);

        while (random_sent < RANDOM_WORDS)
        begin
            sel   = 3'($urandom_range(0, 7));
            alg_d = 16'($urandom);
            r = $urandom_range(0, 19);
            if (r < 13)      cnt_d = 16'($urandom_range(1, 8));
            else if (r < 16) cnt_d = 16'd32;
            else if (r < 17) cnt_d = 16'd0;
            else if (r < 18) cnt_d = 16'($urandom_range(33, 63));
            else             cnt_d = 16'($urandom_range(9, 31));
            cnt_d[15:6] = 10'($urandom);
            r = $urandom_range(0, 19);
            if (r < 10)      unit_d = 16'($urandom_range(1, 3000));
            else if (r < 14) unit_d = 16'($urandom);
            else if (r < 16) unit_d = 16'd1;
            else if (r < 18) unit_d = 16'hFFFF;
            else if (r < 19) unit_d = 16'd0;
            else             unit_d = TICKET_UNIT_RESET;
            program_regs(sel[0], sel[1], sel[2], alg_d, cnt_d, unit_d);

            phase_len = $urandom_range(8, 40);
            done_pct  = $urandom_range(10, 70);
            if ($urandom_range(0, 9) != 0)
            begin
                send_word(CMD_START, 1'($urandom_range(0, 1)), random_draw());
                random_sent++;
            end
            repeat (phase_len)
            begin
                if (fin_cnt >= live_tasks() && $urandom_range(0, 2) != 0)
                    cmd = CMD_START;
                else if ($urandom_range(0, 39) == 0)
                    cmd = CMD_START;
                else
                    cmd = CMD_TICK;
                send_word(cmd, ($urandom_range(0, 99) < done_pct), random_draw());
                random_sent++;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb_round_robin_lottery_task_picker_unit OK");
        else
            $display("tb_round_robin_lottery_task_picker_unit NOT OK");
        $finish;
    end

endmodule

@@ round_robin_lottery_task_picker_unit.f @@
rtl/rrltp_pkg.sv
rtl/round_robin_lottery_task_picker_unit.sv
tb/sv/rrltp_schedule_checker.sv
tb/sv/tb_round_robin_lottery_task_picker_unit.sv
